@@ src/hvt_pkg.sv @@
`timescale 1ns / 1ps
// hvt_pkg: widths, stage counts, register indexes and reset matrix for the
// homogeneous vertex transform core. No dependencies.
package hvt_pkg;

	localparam int XW         = 32;
	localparam int FRAC       = 8;
	localparam int CFG_W      = 64;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = $clog2(NUM_REGS);
	localparam int NUM_ENT    = 2 * NUM_REGS;
	localparam int ENT_W      = $clog2(NUM_ENT);
	localparam int NROWS      = 4;
	localparam int NLANES     = 3;
	localparam int DIV_STAGES = XW;
	// three arithmetic stages, divide setup, divide steps, output
	localparam int STAGES     = 3 + 1 + DIV_STAGES + 1;

	localparam int ROW_W = NROWS - 1;

	typedef logic signed [XW-1:0] fx_t;
	typedef logic [XW-1:0]        mag_t;
	typedef logic [IDX_W-1:0]     cfg_idx_t;

	localparam fx_t FX_ONE  = fx_t'(1 << FRAC);
	localparam fx_t FX_ZERO = '0;

	// row-major entry holding the constant term of each row
	localparam int COL_TRANSL = 3;

	function automatic fx_t reset_entry(input int i);
		fx_t v;
		v = FX_ZERO;
		if (i % (NROWS + 1) == 0) begin
			v = FX_ONE;
		end
		return v;
	endfunction

endpackage

@@ src/homogeneous_vertex_transform_core.sv @@
`timescale 1ns / 1ps
// homogeneous_vertex_transform_core: 4x4 fixed-point point transform with a
// pipelined perspective divide. Depends on hvt_pkg.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | point_x, point_y, point_z
//  out     | output    | out_valid/out_stall | result_x/y/z, was_divided, zero_w_error
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One point per cycle; a 32-step restoring divider (one quotient bit per stage)
// sits behind multiply, two adder stages and divide setup. All stages advance
// together; the pipeline holds only while the output register is full and
// stalled. Reset clears the valid bits and loads the identity matrix.
module homogeneous_vertex_transform_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           point_x,
	input  logic signed [31:0]           point_y,
	input  logic signed [31:0]           point_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           result_x,
	output logic signed [31:0]           result_y,
	output logic signed [31:0]           result_z,
	output logic                         was_divided,
	output logic                         zero_w_error,
	input  logic                         cfg_we,
	input  hvt_pkg::cfg_idx_t            cfg_index,
	input  logic [hvt_pkg::CFG_W-1:0]    cfg_data
);

	hvt_pkg::fx_t mat_q [hvt_pkg::NUM_ENT];
	logic [hvt_pkg::STAGES-1:0] vld_s;
	logic en;

	hvt_pkg::fx_t prod_s1 [hvt_pkg::NROWS][hvt_pkg::NLANES];
	hvt_pkg::fx_t suma_s2 [hvt_pkg::NROWS];
	hvt_pkg::fx_t sumb_s2 [hvt_pkg::NROWS];
	hvt_pkg::fx_t sum_s3  [hvt_pkg::NROWS];

	hvt_pkg::mag_t dv_rem_s [hvt_pkg::DIV_STAGES+1][hvt_pkg::NLANES];
	hvt_pkg::mag_t dv_nq_s  [hvt_pkg::DIV_STAGES+1][hvt_pkg::NLANES];
	logic          dv_neg_s [hvt_pkg::DIV_STAGES+1][hvt_pkg::NLANES];
	hvt_pkg::mag_t dv_den_s [hvt_pkg::DIV_STAGES+1];
	logic          dv_div_s [hvt_pkg::DIV_STAGES+1];
	logic          dv_err_s [hvt_pkg::DIV_STAGES+1];

	hvt_pkg::fx_t res_s [hvt_pkg::NLANES];
	logic         div_s;
	logic         err_s;

	hvt_pkg::fx_t pt [hvt_pkg::NLANES];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// advance everything unless the output beat is held
	assign en        = !(vld_s[hvt_pkg::STAGES-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[hvt_pkg::STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[hvt_pkg::STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::NUM_ENT; i++) begin
				mat_q[i] <= hvt_pkg::reset_entry(i);
			end
		end else if (cfg_we) begin
			mat_q[{cfg_index, 1'b0}] <= cfg_data[hvt_pkg::XW-1:0];
			mat_q[{cfg_index, 1'b1}] <= cfg_data[hvt_pkg::CFG_W-1:hvt_pkg::XW];
		end
	end

	// stage 1: twelve products, scaled back to 24.8
	always_ff @(posedge clk) begin
		logic signed [2*hvt_pkg::XW-1:0] full;
		if (en) begin
			for (int r = 0; r < hvt_pkg::NROWS; r++) begin
				for (int c = 0; c < hvt_pkg::NLANES; c++) begin
					full = pt[c] * mat_q[hvt_pkg::ENT_W'(r * hvt_pkg::NROWS + c)];
					prod_s1[r][c] <= full[hvt_pkg::XW+hvt_pkg::FRAC-1:hvt_pkg::FRAC];
				end
			end
		end
	end

	// stage 2: pair sums, translation folded in
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < hvt_pkg::NROWS; r++) begin
				suma_s2[r] <= prod_s1[r][0] + prod_s1[r][1];
				sumb_s2[r] <= prod_s1[r][2] +
					mat_q[hvt_pkg::ENT_W'(r * hvt_pkg::NROWS + hvt_pkg::COL_TRANSL)];
			end
		end
	end

	// stage 3: row totals
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < hvt_pkg::NROWS; r++) begin
				sum_s3[r] <= suma_s2[r] + sumb_s2[r];
			end
		end
	end

	// divide setup: pass-through and zero w become a divide by one
	always_ff @(posedge clk) begin
		logic         divide;
		logic         zero;
		hvt_pkg::fx_t w;
		hvt_pkg::fx_t num;
		hvt_pkg::fx_t den;
		if (en) begin
			w      = sum_s3[hvt_pkg::ROW_W];
			divide = (w != hvt_pkg::FX_ONE);
			zero   = (w == hvt_pkg::FX_ZERO);
			den    = (divide && !zero) ? w : hvt_pkg::fx_t'(1);
			dv_den_s[0] <= den[hvt_pkg::XW-1] ? hvt_pkg::mag_t'(-den) : hvt_pkg::mag_t'(den);
			dv_div_s[0] <= divide;
			dv_err_s[0] <= zero;
			for (int l = 0; l < hvt_pkg::NLANES; l++) begin
				if (!divide) begin
					num = sum_s3[l];
				end else if (zero) begin
					num = hvt_pkg::FX_ZERO;
				end else begin
					num = sum_s3[l] <<< hvt_pkg::FRAC;
				end
				dv_rem_s[0][l] <= '0;
				dv_nq_s[0][l]  <= num[hvt_pkg::XW-1] ?
					hvt_pkg::mag_t'(-num) : hvt_pkg::mag_t'(num);
				dv_neg_s[0][l] <= num[hvt_pkg::XW-1] ^ den[hvt_pkg::XW-1];
			end
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 0; k < hvt_pkg::DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[k+1] <= dv_den_s[k];
				dv_div_s[k+1] <= dv_div_s[k];
				dv_err_s[k+1] <= dv_err_s[k];
			end
		end
		for (genvar l = 0; l < hvt_pkg::NLANES; l++) begin : g_lane
			logic [hvt_pkg::XW:0] trial;
			logic                 ge;
			assign trial = {dv_rem_s[k][l], dv_nq_s[k][l][hvt_pkg::XW-1]};
			assign ge    = trial >= {1'b0, dv_den_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k+1][l] <= ge ?
						hvt_pkg::mag_t'(trial - {1'b0, dv_den_s[k]}) : trial[hvt_pkg::XW-1:0];
					dv_nq_s[k+1][l]  <= {dv_nq_s[k][l][hvt_pkg::XW-2:0], ge};
					dv_neg_s[k+1][l] <= dv_neg_s[k][l];
				end
			end
		end
	end

	// output register: restore sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < hvt_pkg::NLANES; l++) begin
				res_s[l] <= dv_neg_s[hvt_pkg::DIV_STAGES][l] ?
					hvt_pkg::fx_t'(-dv_nq_s[hvt_pkg::DIV_STAGES][l]) :
					hvt_pkg::fx_t'(dv_nq_s[hvt_pkg::DIV_STAGES][l]);
			end
			div_s <= dv_div_s[hvt_pkg::DIV_STAGES];
			err_s <= dv_err_s[hvt_pkg::DIV_STAGES];
		end
	end

	assign result_x     = res_s[0];
	assign result_y     = res_s[1];
	assign result_z     = res_s[2];
	assign was_divided  = div_s;
	assign zero_w_error = err_s;

endmodule

@@ src/hvt_checker.sv @@
`timescale 1ns / 1ps
// hvt_checker: port-level checks for homogeneous_vertex_transform_core,
// bound to the top level. Depends only on the top level's port list.
module hvt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [31:0]        result_x,
	input logic signed [31:0]        result_y,
	input logic signed [31:0]        result_z,
	input logic                      was_divided,
	input logic                      zero_w_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_x) && $stable(result_y) &&
			$stable(result_z) && $stable(was_divided) && $stable(zero_w_error))
		else $error("held output beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");

	a_err_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_w_error |-> was_divided)
		else $error("zero w without divide flag");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_w_error |-> result_x == 0 && result_y == 0 && result_z == 0)
		else $error("zero w with nonzero coordinates");

endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (.*);
